@@ sv/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and codes shared by the sorted score table and its cells.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int POINTS_BITS = 9;
   localparam int STATUS_BITS = 3;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADDED    = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_BANNED   = 3'd2,
      ST_DISQUAL  = 3'd3,
      ST_FULL     = 3'd4,
      ST_READ_OK  = 3'd5,
      ST_EMPTY    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_LOCATE,
      S_PLACE,
      S_WRITE
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LEFT,
      OP_RIGHT,
      OP_LOAD
   } cell_op_type;

   typedef struct packed {
      logic match;
      logic lt;
      logic gt;
   } cell_flags_type;

endpackage

@@ sv/ssc_cell.sv @@
// ----------------------------------------------------------------------------
// ssc_cell
// One slot of the sorted table. It holds an id and a score, compares them
// against the current key, and takes its neighbor's word on a shift.
// ----------------------------------------------------------------------------
module ssc_cell #(
   parameter int ID_BITS    = 10,
   parameter int SCORE_BITS = 16
) (
   input  logic                   clock,
   input  ssc_pkg::cell_op_type   op,
   input  logic [ID_BITS-1:0]     left_id,
   input  logic [SCORE_BITS-1:0]  left_score,
   input  logic [ID_BITS-1:0]     right_id,
   input  logic [SCORE_BITS-1:0]  right_score,
   input  logic [ID_BITS-1:0]     load_id,
   input  logic [SCORE_BITS-1:0]  load_score,
   input  logic [ID_BITS-1:0]     key_id,
   input  logic [SCORE_BITS-1:0]  key_score,
   output logic [ID_BITS-1:0]     id_q,
   output logic [SCORE_BITS-1:0]  score_q,
   output ssc_pkg::cell_flags_type flags
);
   import ssc_pkg::*;

   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;

   always_comb begin
      unique case (op)
         OP_HOLD: begin
            id_in    = id_ff;
            score_in = score_ff;
         end
         OP_LEFT: begin
            id_in    = left_id;
            score_in = left_score;
         end
         OP_RIGHT: begin
            id_in    = right_id;
            score_in = right_score;
         end
         OP_LOAD: begin
            id_in    = load_id;
            score_in = load_score;
         end
         default: begin
            id_in    = id_ff;
            score_in = score_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      score_ff <= score_in;
   end

   assign id_q        = id_ff;
   assign score_q     = score_ff;
   assign flags.match = (id_ff == key_id);
   assign flags.lt    = (score_ff < key_score);
   assign flags.gt    = (score_ff > key_score);

endmodule

@@ sv/ssc_ban_mem.sv @@
// ----------------------------------------------------------------------------
// ssc_ban_mem
// One ban bit per id. After reset a sweep clears every bit, one a cycle.
// ----------------------------------------------------------------------------
module ssc_ban_mem #(
   parameter int ID_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [ID_BITS-1:0] rd_addr,
   input  logic               wr_en,
   input  logic [ID_BITS-1:0] wr_addr,
   output logic               rd_data,
   output logic               busy
);
   logic                 mem [2**ID_BITS];
   logic [ID_BITS:0]     clr_ff, clr_in;
   logic                 rd_ff;

   assign busy   = ~clr_ff[ID_BITS];
   assign clr_in = busy ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_ff[ID_BITS-1:0]] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

@@ sv/sorted_score_table.sv @@
// ----------------------------------------------------------------------------
// sorted_score_table
// Table of (id, score) entries kept in descending score order in a row of
// cells, with a ban bit per id.
// ----------------------------------------------------------------------------
//   channel | direction | words
//   req     | in        | req_type, participant_id, points, read_rank
//   rsp     | out       | status, rank, entry_id, entry_score, entry_count
//
// Each word passes these steps in turn: fetch of the ban bit and id compare in every
// cell, encoding of the matched slot, score compare in every cell, and a
// last step in which all cells shift at once and the result is registered.
// After reset the ban memory is cleared bit by bit; no word is taken until
// then. A stalled result holds the block in its last step.
module sorted_score_table #(
   parameter int CAPACITY   = 512,
   parameter int ID_BITS    = 10,
   parameter int SCORE_BITS = 16,
   localparam int RANK_BITS  = $clog2(CAPACITY),
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [ID_BITS-1:0]      req_participant_id,
   input  logic signed [ssc_pkg::POINTS_BITS-1:0] req_points,
   input  logic [RANK_BITS-1:0]    req_read_rank,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ssc_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [RANK_BITS-1:0]    rsp_rank,
   output logic [ID_BITS-1:0]      rsp_entry_id,
   output logic [SCORE_BITS-1:0]   rsp_entry_score,
   output logic [COUNT_BITS-1:0]   rsp_entry_count
);
   import ssc_pkg::*;

   state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    type_ff;
   logic [ID_BITS-1:0]      id_ff;
   logic [POINTS_BITS-1:0]  points_ff;
   logic [RANK_BITS-1:0]    rr_ff;

   logic [CAPACITY-1:0]     match_ff, match_in;
   logic                    found_ff, found_in;
   logic [RANK_BITS-1:0]    pos_ff, pos_in;
   logic [SCORE_BITS-1:0]   old_ff, old_in;
   logic [SCORE_BITS-1:0]   sc_ff, sc_in;
   logic [CAPACITY-1:0]     flag_ff, flag_in;

   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [RANK_BITS-1:0]    rank_ff, rank_in;
   logic [ID_BITS-1:0]      eid_ff, eid_in;
   logic [SCORE_BITS-1:0]   esc_ff, esc_in;

   logic [ID_BITS-1:0]      cell_id [CAPACITY];
   logic [SCORE_BITS-1:0]   cell_sc [CAPACITY];
   cell_flags_type          cell_fl [CAPACITY];
   cell_op_type             cell_op [CAPACITY];

   logic                    accept;
   logic                    ban_bit;
   logic                    ban_busy;
   logic                    ban_wr;
   logic                    dq;
   logic [7:0]              pts;
   logic [SCORE_BITS:0]     sum;
   logic                    step;
   logic [RANK_BITS-1:0]    first_lt;
   logic                    any_lt;
   logic [RANK_BITS-1:0]    ins_pos;
   logic                    before0;
   logic                    rd_hit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || ban_busy;
   assign dq        = (points_ff == '1);
   assign pts       = points_ff[POINTS_BITS-1] ? 8'd0 : points_ff[7:0];
   assign step      = (state_ff == S_WRITE) && !(rsp_valid_ff && rsp_stall);
   assign rd_hit    = ({1'b0, rr_ff} < (RANK_BITS+1)'(count_ff));

   ssc_ban_mem #(.ID_BITS(ID_BITS)) u_ban (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_participant_id),
      .wr_en   (ban_wr),
      .wr_addr (id_ff),
      .rd_data (ban_bit),
      .busy    (ban_busy)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ssc_cell #(.ID_BITS(ID_BITS), .SCORE_BITS(SCORE_BITS)) u_cell (
         .clock       (clock),
         .op          (cell_op[g]),
         .left_id     (g == 0 ? id_ff : cell_id[(g == 0) ? 0 : g-1]),
         .left_score  (g == 0 ? sc_ff : cell_sc[(g == 0) ? 0 : g-1]),
         .right_id    (cell_id[(g == CAPACITY-1) ? g : g+1]),
         .right_score (cell_sc[(g == CAPACITY-1) ? g : g+1]),
         .load_id     (id_ff),
         .load_score  (sc_ff),
         .key_id      (id_ff),
         .key_score   (sc_in),
         .id_q        (cell_id[g]),
         .score_q     (cell_sc[g]),
         .flags       (cell_fl[g])
      );
   end

   always_comb begin
      found_in = 1'b0;
      pos_in   = '0;
      old_in   = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         match_in[j] = cell_fl[j].match && (COUNT_BITS'(j) < count_ff);
         if (match_ff[j]) begin
            found_in = 1'b1;
            pos_in   = pos_in | RANK_BITS'(j);
            old_in   = old_in | cell_sc[j];
         end
      end
   end

   always_comb begin
      sum   = {1'b0, old_ff} + (SCORE_BITS+1)'(pts);
      sc_in = sc_ff;
      if (state_ff == S_PLACE) begin
         if (found_ff) begin
            sc_in = sum[SCORE_BITS] ? '1 : sum[SCORE_BITS-1:0];
         end else begin
            sc_in = SCORE_BITS'(pts);
         end
      end
      before0 = !cell_fl[0].lt && (count_ff != '0);
      for (int j = 0; j < CAPACITY; j++) begin
         if (found_ff) begin
            flag_in[j] = cell_fl[j].lt && (RANK_BITS'(j) < pos_ff)
                         && (COUNT_BITS'(j) < count_ff);
         end else if (j == 0) begin
            flag_in[j] = before0;
         end else begin
            flag_in[j] = before0 && cell_fl[j].gt && (COUNT_BITS'(j) < count_ff);
         end
      end
   end

   always_comb begin
      any_lt   = 1'b0;
      first_lt = '0;
      ins_pos  = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         if (flag_ff[j] && (j == 0 || !flag_ff[(j == 0) ? 0 : j-1])) begin
            any_lt   = 1'b1;
            first_lt = first_lt | RANK_BITS'(j);
         end
         if (!flag_ff[j] && (j == 0 || flag_ff[(j == 0) ? 0 : j-1])) begin
            ins_pos = ins_pos | RANK_BITS'(j);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      rank_in      = rank_ff;
      eid_in       = eid_ff;
      esc_in       = esc_ff;
      ban_wr       = 1'b0;
      for (int j = 0; j < CAPACITY; j++) begin
         cell_op[j] = OP_HOLD;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            state_in = S_LOCATE;
         end
         S_LOCATE: begin
            state_in = S_PLACE;
         end
         S_PLACE: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (step) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               eid_in       = id_ff;
               rank_in      = '0;
               esc_in       = '0;
               priority if (type_ff) begin
                  rank_in = rr_ff;
                  if (rd_hit) begin
                     status_in = ST_READ_OK;
                     eid_in    = cell_id[rr_ff];
                     esc_in    = cell_sc[rr_ff];
                  end else begin
                     status_in = ST_EMPTY;
                     eid_in    = '0;
                  end
               end else if (ban_bit) begin
                  status_in = ST_BANNED;
               end else if (dq) begin
                  status_in = ST_DISQUAL;
                  ban_wr    = 1'b1;
                  if (found_ff) begin
                     rank_in  = pos_ff;
                     esc_in   = old_ff;
                     count_in = count_ff - 1'b1;
                     for (int j = 0; j < CAPACITY; j++) begin
                        if (RANK_BITS'(j) >= pos_ff) begin
                           cell_op[j] = OP_RIGHT;
                        end
                     end
                  end
               end else if (found_ff) begin
                  status_in = ST_UPDATED;
                  rank_in   = any_lt ? first_lt : pos_ff;
                  esc_in    = sc_ff;
                  for (int j = 0; j < CAPACITY; j++) begin
                     if (flag_ff[j] || RANK_BITS'(j) == pos_ff) begin
                        if (j > 0 && flag_ff[(j == 0) ? 0 : j-1]) begin
                           cell_op[j] = OP_LEFT;
                        end else begin
                           cell_op[j] = OP_LOAD;
                        end
                     end
                  end
               end else if (count_ff == COUNT_BITS'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_ADDED;
                  rank_in   = ins_pos;
                  esc_in    = sc_ff;
                  count_in  = count_ff + 1'b1;
                  for (int j = 0; j < CAPACITY; j++) begin
                     if (!flag_ff[j]) begin
                        if (j == 0 || flag_ff[(j == 0) ? 0 : j-1]) begin
                           cell_op[j] = OP_LOAD;
                        end else begin
                           cell_op[j] = OP_LEFT;
                        end
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff   <= req_type;
         id_ff     <= req_participant_id;
         points_ff <= req_points;
         rr_ff     <= req_read_rank;
      end
      match_ff  <= match_in;
      if (state_ff == S_LOCATE) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
         old_ff   <= old_in;
      end
      sc_ff     <= sc_in;
      if (state_ff == S_PLACE) begin
         flag_ff <= flag_in;
      end
      status_ff <= status_in;
      rank_ff   <= rank_in;
      eid_ff    <= eid_in;
      esc_ff    <= esc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_rank        = rank_ff;
   assign rsp_entry_id    = eid_ff;
   assign rsp_entry_score = esc_ff;
   assign rsp_entry_count = count_ff;

endmodule

@@ sv/ssc_checker.sv @@
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the sorted score table.
// ----------------------------------------------------------------------------
module ssc_checker #(
   parameter int CAPACITY   = 512,
   parameter int ID_BITS    = 10,
   parameter int SCORE_BITS = 16,
   localparam int RANK_BITS  = $clog2(CAPACITY),
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [ssc_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [RANK_BITS-1:0]    rsp_rank,
   input logic [ID_BITS-1:0]      rsp_entry_id,
   input logic [SCORE_BITS-1:0]   rsp_entry_score,
   input logic [COUNT_BITS-1:0]   rsp_entry_count
);
   import ssc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_id) && $stable(rsp_entry_score))
      else $error("Stalled result word changed.");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("A second word was taken while one is in flight.");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_BITS'(CAPACITY))
      else $error("Entry count above capacity.");

   a_rank_in_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_READ_OK || rsp_status == ST_ADDED
         || rsp_status == ST_UPDATED)
      |-> COUNT_BITS'(rsp_rank) < rsp_entry_count)
      else $error("Reported rank lies outside the valid entries.");

endmodule

bind sorted_score_table ssc_checker #(
   .CAPACITY   (CAPACITY),
   .ID_BITS    (ID_BITS),
   .SCORE_BITS (SCORE_BITS)
) u_ssc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_rank        (rsp_rank),
   .rsp_entry_id    (rsp_entry_id),
   .rsp_entry_score (rsp_entry_score),
   .rsp_entry_count (rsp_entry_count)
);

@@ verif/sorted_score_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_score_table_checker
// Watches both channels of the sorted score table. Every accepted request
// word is run through a local copy of the sorted table and its ban bits.
// Every accepted result word is then compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module sorted_score_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [9:0]  req_participant_id,
   input  logic [8:0]  req_points,
   input  logic [8:0]  req_read_rank,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [8:0]  rsp_rank,
   input  logic [9:0]  rsp_entry_id,
   input  logic [15:0] rsp_entry_score,
   input  logic [9:0]  rsp_entry_count,
   output int          pending,
   output int          errors
);
   import ssc_pkg::*;

   typedef struct {
      status_type  status;
      logic [8:0]  rank;
      logic [9:0]  id;
      logic [15:0] score;
      logic [9:0]  count;
   } score_word_type;

   score_word_type expected_words[$];
   logic [9:0]     table_ids[512];
   logic [15:0]    table_scores[512];
   int             table_count;
   bit             id_banned[1024];

   function automatic int find_id(input logic [9:0] id);
      int k;
      for (k = 0; k < table_count; k++)
         if (table_ids[k] == id) return k;
      return table_count;
   endfunction

   task automatic predict_score(input logic t, input logic [9:0] id, input logic [8:0] p,
                                input logic [8:0] rr);
      score_word_type w;
      int             pos;
      int             k;
      int unsigned    pts;
      int unsigned    sc;
      w.rank = '0;
      w.id = id;
      w.score = '0;
      if (t) begin
         w.rank = rr;
         if (rr < table_count) begin
            w.status = ST_READ_OK;
            w.id = table_ids[rr];
            w.score = table_scores[rr];
         end else begin
            w.status = ST_EMPTY;
            w.id = '0;
         end
      end else if (id_banned[id]) begin
         w.status = ST_BANNED;
      end else if (p == 9'h1FF) begin
         w.status = ST_DISQUAL;
         id_banned[id] = 1'b1;
         pos = find_id(id);
         if (pos < table_count) begin
            w.rank = 9'(pos);
            w.score = table_scores[pos];
            for (k = pos; k + 1 < table_count; k++) begin
               table_ids[k] = table_ids[k+1];
               table_scores[k] = table_scores[k+1];
            end
            table_count--;
         end
      end else begin
         pts = p[8] ? 32'd0 : 32'(p);
         pos = find_id(id);
         if (pos < table_count) begin
            sc = 32'(table_scores[pos]) + pts;
            if (sc > 65535) sc = 65535;
            while (pos > 0 && sc > 32'(table_scores[pos-1])) begin
               table_ids[pos] = table_ids[pos-1];
               table_scores[pos] = table_scores[pos-1];
               pos--;
            end
            table_ids[pos] = id;
            table_scores[pos] = 16'(sc);
            w.status = ST_UPDATED;
            w.rank = 9'(pos);
            w.score = 16'(sc);
         end else if (table_count >= 512) begin
            w.status = ST_FULL;
         end else begin
            sc = pts;
            if (table_count == 0 || 32'(table_scores[0]) < sc) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < table_count && 32'(table_scores[pos]) > sc) pos++;
            end
            for (k = table_count; k > pos; k--) begin
               table_ids[k] = table_ids[k-1];
               table_scores[k] = table_scores[k-1];
            end
            table_ids[pos] = id;
            table_scores[pos] = 16'(sc);
            table_count++;
            w.status = ST_ADDED;
            w.rank = 9'(pos);
            w.score = 16'(sc);
         end
      end
      w.count = 10'(table_count);
      expected_words = {expected_words, w};
   endtask

   always @(posedge clock) begin
      score_word_type w;
      if (reset) begin
         errors = 0;
         table_count = 0;
         expected_words.delete();
         foreach (id_banned[k]) id_banned[k] = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               if (errors < 10) $display("unexpected result word: status %0d", rsp_status);
               errors++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_status != w.status || rsp_rank != w.rank || rsp_entry_id != w.id
                   || rsp_entry_score != w.score || rsp_entry_count != w.count) begin
                  if (errors < 10)
                     $display({"mismatch: expected st %0d rk %0d id %0d sc %0d cnt %0d,",
                               " got st %0d rk %0d id %0d sc %0d cnt %0d"},
                              w.status, w.rank, w.id, w.score, w.count, rsp_status,
                              rsp_rank, rsp_entry_id, rsp_entry_score, rsp_entry_count);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_score(req_type, req_participant_id, req_points, req_read_rank);
      end
      pending = expected_words.size();
   end

endmodule

@@ verif/tb_sorted_score_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_score_table
// Drives directed and random score events and rank reads into the sorted
// score table, with random gaps and stalls and one long result hold-off.
// The checker predicts every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_score_table;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [9:0]  req_participant_id = '0;
   logic [8:0]  req_points = '0;
   logic [8:0]  req_read_rank = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [8:0]  rsp_rank;
   logic [9:0]  rsp_entry_id;
   logic [15:0] rsp_entry_score;
   logic [9:0]  rsp_entry_count;
   int          pending;
   int          errors;
   bit          quiet = 1'b0;
   bit          long_hold = 1'b0;
   bit          hold_done = 1'b0;

   sorted_score_table u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_participant_id,
      .req_points, .req_read_rank, .rsp_valid, .rsp_stall, .rsp_status, .rsp_rank,
      .rsp_entry_id, .rsp_entry_score, .rsp_entry_count
   );

   sorted_score_table_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_participant_id,
      .req_points, .req_read_rank, .rsp_valid, .rsp_stall, .rsp_status, .rsp_rank,
      .rsp_entry_id, .rsp_entry_score, .rsp_entry_count, .pending, .errors
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_sorted_score_table NOT OK");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom % 100 < 15);
      end
   end

   task automatic send_word(input logic t, input logic [9:0] id, input logic [8:0] p,
                            input logic [8:0] rr);
      if (!quiet && $urandom % 100 < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_participant_id <= id;
      req_points <= p;
      req_read_rank <= rr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random_score(input logic [9:0] id);
      logic [8:0] p;
      p = ($urandom % 100 < 8) ? 9'($urandom_range(256, 510)) : 9'($urandom_range(0, 255));
      send_word(1'b0, id, p, 9'($urandom));
   endtask

   initial begin
      int n;
      int roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(1'b1, 10'd0, 9'd0, 9'd0);
      send_word(1'b1, 10'd0, 9'd0, 9'd511);
      send_word(1'b0, 10'd5, 9'd10, 9'd0);
      send_word(1'b0, 10'd6, 9'd10, 9'd0);
      send_word(1'b0, 10'd7, 9'd10, 9'd0);
      send_word(1'b0, 10'd8, 9'd255, 9'd0);
      send_word(1'b0, 10'd5, 9'd0, 9'd0);
      send_word(1'b0, 10'd6, 9'h1FE, 9'd0);
      send_word(1'b0, 10'd9, 9'h100, 9'd0);
      send_word(1'b0, 10'd1023, 9'd255, 9'd0);
      send_word(1'b0, 10'd0, 9'd0, 9'd0);
      send_word(1'b0, 10'd6, 9'd1, 9'd0);
      send_word(1'b0, 10'd7, 9'h1FF, 9'd0);
      send_word(1'b0, 10'd7, 9'd5, 9'd0);
      send_word(1'b0, 10'd100, 9'h1FF, 9'd0);
      send_word(1'b1, 10'd0, 9'd0, 9'd0);
      send_word(1'b1, 10'd0, 9'd0, 9'd1);
      send_word(1'b1, 10'd0, 9'd0, 9'd3);
      send_word(1'b1, 10'd0, 9'd0, 9'd8);

      // Score one id until its score saturates.
      for (n = 0; n < 260; n++) send_word(1'b0, 10'd8, 9'd255, 9'($urandom));

      // Fill the table with fresh ids, with a long result hold-off early on.
      for (n = 0; n < 600; n++) begin
         if (n == 40) long_hold = 1'b1;
         quiet = (n >= 300 && n < 420);
         send_random_score(10'((n * 37 + 11) % 1024));
      end
      quiet = 1'b0;

      for (n = 0; n < 1070; n++) begin
         roll = $urandom % 100;
         if (roll < 35)
            send_word(1'b1, 10'($urandom), 9'($urandom),
                      ($urandom % 4 == 0) ? 9'($urandom) : 9'($urandom_range(0, 40)));
         else if (roll < 38)
            send_word(1'b0, 10'($urandom), 9'h1FF, 9'($urandom));
         else
            send_random_score(10'($urandom));
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("tb_sorted_score_table OK");
      else
         $display("tb_sorted_score_table NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
sv/ssc_pkg.sv
sv/ssc_cell.sv
sv/ssc_ban_mem.sv
sv/sorted_score_table.sv
sv/ssc_checker.sv
verif/sorted_score_table_checker.sv
verif/tb_sorted_score_table.sv
